@@ hdl/sdc_pkg.sv @@
package sdc_pkg;

   // Port field widths
   localparam int unsigned VALUE_WIDTH = 10;
   localparam int unsigned CFG_WIDTH   = 9;
   localparam int unsigned OUT_WIDTH   = 9;

   // Key space of the count store
   localparam int unsigned VALUE_BITS = 10;
   localparam int unsigned KEY_COUNT  = 1 << VALUE_BITS;

   // Window limits
   localparam int unsigned WINDOW_MAX = 256;
   localparam int unsigned POS_BITS   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int unsigned CNT_BITS   = $clog2(WINDOW_MAX + 1);

   localparam logic [CFG_WIDTH-1:0] WINDOW_RESET = CFG_WIDTH'(4);

   // Sequence tag kept next to every count
   localparam int unsigned EPOCH_BITS = 8;
   localparam logic [EPOCH_BITS-1:0] EPOCH_MAX = '1;

   typedef struct packed {
      logic [EPOCH_BITS-1:0] tag;
      logic [CNT_BITS-1:0]   count;
   } count_entry_type;

   localparam int unsigned ENTRY_BITS = EPOCH_BITS + CNT_BITS;

   typedef enum logic {
      ST_CLEAR,
      ST_RUN
   } sdc_state_type;

   // Clamp the programmed window into 1..WINDOW_MAX
   function automatic logic [CNT_BITS-1:0] eff_window(input logic [CFG_WIDTH-1:0] ws);
      logic [CNT_BITS-1:0] w;
      if (ws == '0) begin
         w = CNT_BITS'(1);
      end else if (32'(ws) > 32'(WINDOW_MAX)) begin
         w = CNT_BITS'(WINDOW_MAX);
      end else begin
         w = CNT_BITS'(ws);
      end
      return w;
   endfunction

endpackage

@@ hdl/sliding_window_distinct_count.sv @@
// Sliding-window distinct count.
// Input channel (req_): one word per stream element, req_value plus req_restart,
// which starts a new sequence before this element. Result channel (rsp_): one
// word holding rsp_distinct_count for every element that completes a full
// window; elements that only fill the window give no result.
// Config channel (csr_): writes window_size and always restarts the sequence at
// the next element; csr_ready is always high.
// An element passes stage B, stage C and the result queue's output word before
// rsp_valid rises. No element is taken while the one before it is in stage B:
// each element does two read-modify-write passes (increment of the arriving
// value, decrement of the leaving one) through the single write port of the
// count store. Reset: the count store is swept key by key, over all 1024 keys,
// with req_stall high. Counts carry an 8-bit sequence tag; after 255 restarts
// the next restart triggers the same sweep once in-flight elements drain. A
// stalled result waits in a two-word output queue; input is also held off when
// that queue could overflow, so a stalling receiver throttles the input.
module sliding_window_distinct_count (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [sdc_pkg::VALUE_WIDTH-1:0] req_value,
   input  logic                            req_restart,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [sdc_pkg::OUT_WIDTH-1:0]   rsp_distinct_count,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [sdc_pkg::CFG_WIDTH-1:0]   csr_window_size
);
   import sdc_pkg::*;

   // Control registers
   sdc_state_type         state_ff, state_in;
   logic [VALUE_BITS-1:0] clr_addr_ff, clr_addr_in;
   logic [EPOCH_BITS-1:0] epoch_ff, epoch_in;
   logic [CFG_WIDTH-1:0]  window_ff;
   logic                  restart_pend_ff;
   logic [POS_BITS-1:0]   ring_pos_ff;
   logic [CNT_BITS-1:0]   fill_ff;
   logic [CNT_BITS-1:0]   total_ff, total_in;

   // Stage B: increment of the arriving value
   logic                  b_valid_ff;
   logic [VALUE_BITS-1:0] b_key_ff;
   logic                  b_leave_ff;
   logic                  b_produce_ff;
   logic                  b_restart_ff;

   // Stage C: decrement of the leaving value
   logic                  c_valid_ff;
   logic [VALUE_BITS-1:0] c_key_ff;
   logic                  c_leave_ff;
   logic                  c_produce_ff;

   // Stage A (accept) signals
   logic                  acc;
   logic                  clr_wr;
   logic                  restart_eff;
   logic [CNT_BITS-1:0]   win;
   logic [VALUE_BITS-1:0] a_key;
   logic [POS_BITS-1:0]   pos0;
   logic [POS_BITS-1:0]   a_pos;
   logic [POS_BITS-1:0]   a_pos_next;
   logic [CNT_BITS-1:0]   pos_inc;
   logic [CNT_BITS-1:0]   fill0;
   logic                  a_full;
   logic [CNT_BITS-1:0]   a_fill;
   logic                  a_produce;

   // Store access
   logic                  cs_rd_en;
   logic [VALUE_BITS-1:0] cs_rd_addr;
   logic                  cs_wr_en;
   logic [VALUE_BITS-1:0] cs_wr_addr;
   count_entry_type       cs_wr_data;
   count_entry_type       cs_rd_data;
   logic [VALUE_BITS-1:0] ring_q;

   // Update arithmetic
   logic [CNT_BITS-1:0]   cur_count;
   logic [CNT_BITS-1:0]   b_new;
   logic                  b_inc;
   logic                  c_dec_ok;
   logic [CNT_BITS-1:0]   c_new;
   logic                  c_drop;
   logic [CNT_BITS-1:0]   total_dec;

   // Result queue
   logic                  push;
   logic [1:0]            q_level;

   assign csr_ready = 1'b1;
   assign acc       = req_valid && !req_stall;

   // Window bookkeeping at accept
   assign win         = eff_window(window_ff);
   assign restart_eff = req_restart || restart_pend_ff;
   assign a_key       = VALUE_BITS'(req_value);
   assign pos0        = restart_eff ? '0 : ring_pos_ff;
   assign fill0       = restart_eff ? '0 : fill_ff;
   assign a_pos       = (CNT_BITS'(pos0) >= win) ? '0 : pos0;
   assign a_full      = (fill0 >= win);
   assign a_fill      = a_full ? win : fill0 + CNT_BITS'(1);
   assign a_produce   = (a_fill >= win);
   assign pos_inc     = CNT_BITS'(a_pos) + CNT_BITS'(1);
   assign a_pos_next  = (pos_inc >= win) ? '0 : POS_BITS'(pos_inc);

   // Sequencer: clearing sweep and input admission
   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      clr_wr      = 1'b0;
      req_stall   = 1'b1;
      case (state_ff)
         ST_CLEAR: begin
            clr_wr      = 1'b1;
            clr_addr_in = clr_addr_ff + VALUE_BITS'(1);
            if (clr_addr_ff == '1) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            req_stall = b_valid_ff
                     || ((q_level + {1'b0, c_valid_ff}) > 2'd1)
                     || (restart_eff && (epoch_ff == EPOCH_MAX));
            if (req_valid && restart_eff && (epoch_ff == EPOCH_MAX)
                && !b_valid_ff && !c_valid_ff) begin
               state_in    = ST_CLEAR;
               clr_addr_in = '0;
            end
         end
         default: begin
            state_in    = ST_CLEAR;
            clr_addr_in = '0;
         end
      endcase
   end

   // Advance the sequence tag on restart, drop it back after a sweep
   always_comb begin
      epoch_in = epoch_ff;
      if ((state_ff == ST_CLEAR) && (clr_addr_ff == '1)) begin
         epoch_in = '0;
      end else if (acc && restart_eff) begin
         epoch_in = epoch_ff + EPOCH_BITS'(1);
      end
   end

   // Ring of recent keys: read the leaving key and write the arriving one
   sdc_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (WINDOW_MAX)
   ) u_ring (
      .clock   (clock),
      .wr_en   (acc),
      .wr_addr (a_pos),
      .wr_data (a_key),
      .rd_en   (acc),
      .rd_addr (a_pos),
      .rd_data (ring_q)
   );

   // Counts from another sequence read as zero
   assign cur_count = (cs_rd_data.tag == epoch_ff) ? cs_rd_data.count : '0;
   assign b_new     = cur_count + CNT_BITS'(1);
   assign b_inc     = (cur_count == '0);
   assign c_dec_ok  = c_leave_ff && (cur_count != '0);
   assign c_new     = cur_count - CNT_BITS'(1);
   assign c_drop    = c_dec_ok && (c_new == '0) && (total_ff != '0);
   assign total_dec = total_ff - CNT_BITS'(c_drop);

   // Count store read: arriving key at accept, leaving key in stage B
   assign cs_rd_en   = acc || (b_valid_ff && b_leave_ff);
   assign cs_rd_addr = b_valid_ff ? ring_q : a_key;

   // Count store write: sweep, increment or decrement
   always_comb begin
      cs_wr_en   = 1'b0;
      cs_wr_addr = b_key_ff;
      cs_wr_data = '0;
      if (clr_wr) begin
         cs_wr_en   = 1'b1;
         cs_wr_addr = clr_addr_ff;
      end else if (b_valid_ff) begin
         cs_wr_en   = 1'b1;
         cs_wr_data = '{tag: epoch_ff, count: b_new};
      end else if (c_valid_ff && c_dec_ok) begin
         cs_wr_en   = 1'b1;
         cs_wr_addr = c_key_ff;
         cs_wr_data = '{tag: epoch_ff, count: c_new};
      end
   end

   sdc_count_store u_counts (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (cs_rd_en),
      .rd_addr (cs_rd_addr),
      .wr_en   (cs_wr_en),
      .wr_addr (cs_wr_addr),
      .wr_data (cs_wr_data),
      .rd_data (cs_rd_data)
   );

   // Distinct total: raise in stage B, lower in stage C
   always_comb begin
      total_in = total_ff;
      if (b_valid_ff) begin
         total_in = (b_restart_ff ? '0 : total_ff) + CNT_BITS'(b_inc);
      end else if (c_valid_ff) begin
         total_in = total_dec;
      end
   end

   assign push = c_valid_ff && c_produce_ff;

   sdc_rsp_queue u_rsp (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (OUT_WIDTH'(total_dec)),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_distinct_count),
      .level     (q_level)
   );

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         clr_addr_ff     <= '0;
         epoch_ff        <= '0;
         window_ff       <= WINDOW_RESET;
         restart_pend_ff <= 1'b0;
         ring_pos_ff     <= '0;
         fill_ff         <= '0;
         total_ff        <= '0;
         b_valid_ff      <= 1'b0;
         c_valid_ff      <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         epoch_ff    <= epoch_in;
         total_ff    <= total_in;
         b_valid_ff  <= acc;
         c_valid_ff  <= b_valid_ff;
         if (acc) begin
            ring_pos_ff     <= a_pos_next;
            fill_ff         <= a_fill;
            restart_pend_ff <= 1'b0;
         end
         if (csr_valid) begin
            window_ff       <= csr_window_size;
            restart_pend_ff <= 1'b1;
         end
      end
   end

   // Stage payloads
   always_ff @(posedge clock) begin
      if (acc) begin
         b_key_ff     <= a_key;
         b_leave_ff   <= a_full;
         b_produce_ff <= a_produce;
         b_restart_ff <= restart_eff;
      end
      c_key_ff     <= ring_q;
      c_leave_ff   <= b_leave_ff;
      c_produce_ff <= b_produce_ff;
   end

   // Stages B and C share the store write port on alternate cycles
   a_stage_overlap: assert property (@(posedge clock) disable iff (reset)
      !(b_valid_ff && c_valid_ff))
      else $error("stages B and C active together");

   // The sweep runs only with the pipeline drained
   a_clear_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> (!b_valid_ff && !c_valid_ff))
      else $error("clearing sweep overlaps an element in flight");

   // The sequence tag moves only with an accepted element or a sweep
   a_epoch_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) && !acc |=> $stable(epoch_ff))
      else $error("sequence tag changed without an accepted element");

   // A full window always holds at least the arriving value
   a_total_nonzero: assert property (@(posedge clock) disable iff (reset)
      push |-> (total_dec != '0))
      else $error("result with zero distinct values");

   // Admission keeps room in the result queue
   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      push |-> (q_level < 2'd2))
      else $error("result pushed into a full queue");

endmodule

@@ hdl/sdc_ram.sv @@
module sdc_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16,
   localparam int unsigned ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port, old data on a same-address collision
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/sdc_count_store.sv @@
module sdc_count_store (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           rd_en,
   input  logic [sdc_pkg::VALUE_BITS-1:0] rd_addr,
   input  logic                           wr_en,
   input  logic [sdc_pkg::VALUE_BITS-1:0] wr_addr,
   input  sdc_pkg::count_entry_type       wr_data,
   output sdc_pkg::count_entry_type       rd_data
);
   import sdc_pkg::*;

   logic                  fwd_ff;
   logic                  fwd_in;
   count_entry_type       fwd_data_ff;
   logic [ENTRY_BITS-1:0] ram_q;

   sdc_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (KEY_COUNT)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (ENTRY_BITS'(wr_data)),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // Catch a read that hits the entry being written in the same cycle
   assign fwd_in = rd_en && wr_en && (rd_addr == wr_addr);

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else begin
         fwd_ff <= fwd_in;
      end
      fwd_data_ff <= wr_data;
   end

   // Prefer the forwarded entry over the stale memory word
   assign rd_data = fwd_ff ? fwd_data_ff : count_entry_type'(ram_q);

endmodule

@@ hdl/sdc_rsp_queue.sv @@
module sdc_rsp_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  logic [sdc_pkg::OUT_WIDTH-1:0] push_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [sdc_pkg::OUT_WIDTH-1:0] rsp_data,
   output logic [1:0]                    level
);
   import sdc_pkg::*;

   logic                 out_valid_ff, out_valid_in;
   logic [OUT_WIDTH-1:0] out_data_ff, out_data_in;
   logic                 skid_valid_ff, skid_valid_in;
   logic [OUT_WIDTH-1:0] skid_data_ff, skid_data_in;
   logic                 take;

   assign take = out_valid_ff && !rsp_stall;

   // Refill the output word from the skid stage first, then from the pipeline
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || take) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = push;
            skid_data_in  = push_data;
         end else begin
            out_valid_in = push;
            out_data_in  = push_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;
   assign level     = {1'b0, out_valid_ff} + {1'b0, skid_valid_ff};

endmodule

@@ tb/sv/distinct_count_checker.sv @@
`timescale 1ns / 100ps

module distinct_count_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic [sdc_pkg::VALUE_WIDTH-1:0] req_value,
   input  logic                            req_restart,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [sdc_pkg::OUT_WIDTH-1:0]   rsp_distinct_count,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [sdc_pkg::CFG_WIDTH-1:0]   csr_window_size,
   output int                              mismatch_count,
   output int                              pending_words
);

   localparam int unsigned KEYS         = sdc_pkg::KEY_COUNT;
   localparam int unsigned REPORT_LIMIT = 10;

   // Shadow copy of the window state
   logic [sdc_pkg::CNT_BITS-1:0]   key_tally [KEYS];
   logic [sdc_pkg::VALUE_BITS-1:0] ring_vals [sdc_pkg::WINDOW_MAX];
   int unsigned                    slot;
   int unsigned                    filled;
   logic [sdc_pkg::OUT_WIDTH-1:0]  distinct;
   logic [sdc_pkg::CFG_WIDTH-1:0]  window_reg;

   // Distinct counts still owed by the block, oldest first
   logic [sdc_pkg::OUT_WIDTH-1:0]  expected_counts [$];

   // Drop all counts and start an empty window
   task automatic clear_window_state();
      for (int k = 0; k < KEYS; k++) begin
         key_tally[k] = '0;
      end
      slot     = 0;
      filled   = 0;
      distinct = '0;
   endtask

   // Slide one element into the window and queue the count it yields
   task automatic track_element(input logic [sdc_pkg::VALUE_WIDTH-1:0] raw,
                                input logic restart);
      int unsigned                    w;
      logic [sdc_pkg::VALUE_BITS-1:0] key;
      logic [sdc_pkg::VALUE_BITS-1:0] leaving;
      // zero acts as a window of one, oversize as the largest window
      if (window_reg == '0) begin
         w = 1;
      end else if (window_reg > sdc_pkg::WINDOW_MAX) begin
         w = sdc_pkg::WINDOW_MAX;
      end else begin
         w = window_reg;
      end
      key = raw[sdc_pkg::VALUE_BITS-1:0];
      if (restart) begin
         clear_window_state();
      end
      // arriving value counts first, so a value that leaves and arrives cancels
      if (key_tally[key] == '0) begin
         distinct = distinct + 1'b1;
      end
      key_tally[key] = key_tally[key] + 1'b1;
      if (slot >= w) begin
         slot = 0;
      end
      if (filled >= w) begin
         leaving = ring_vals[slot];
         if (key_tally[leaving] != '0) begin
            key_tally[leaving] = key_tally[leaving] - 1'b1;
            if (key_tally[leaving] == '0 && distinct != '0) begin
               distinct = distinct - 1'b1;
            end
         end
         filled = w;
      end else begin
         filled++;
      end
      ring_vals[slot] = key;
      slot = (slot + 1 >= w) ? 0 : slot + 1;
      if (filled >= w) begin
         expected_counts.insert(expected_counts.size(), distinct);
      end
   endtask

   // Watch all three channels at the rising edge
   always @(posedge clock) begin : watch
      logic [sdc_pkg::OUT_WIDTH-1:0] want;
      if (reset) begin
         window_reg = sdc_pkg::WINDOW_RESET;
         clear_window_state();
         for (int k = 0; k < sdc_pkg::WINDOW_MAX; k++) begin
            ring_vals[k] = '0;
         end
         expected_counts.delete();
         mismatch_count = 0;
      end else begin
         // compare a result word against the oldest expectation
         if (rsp_valid && !rsp_stall) begin
            if (expected_counts.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("%0t: unexpected result word, distinct_count %0d, none pending",
                           $time, rsp_distinct_count);
               end
            end else begin
               want = expected_counts.pop_front();
               if (rsp_distinct_count !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT) begin
                     $display("%0t: distinct_count mismatch, expected %0d, actual %0d",
                              $time, want, rsp_distinct_count);
                  end
               end
            end
         end
         // a window write restarts the sequence
         if (csr_valid && csr_ready) begin
            window_reg = csr_window_size;
            clear_window_state();
         end
         if (req_valid && !req_stall) begin
            track_element(req_value, req_restart);
         end
      end
      pending_words = expected_counts.size();
   end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

   localparam int unsigned CYCLE_LIMIT      = 600000;
   localparam int unsigned SETTLE_CYCLES    = 12;
   localparam int unsigned STIMULUS_ITEMS   = 2000;
   localparam int unsigned MAX_GAP          = 11;
   localparam int unsigned HOLD_AT_RESULT   = 40;
   localparam int unsigned LONG_HOLD_CYCLES = 400;

   localparam logic [sdc_pkg::CFG_WIDTH-1:0] WINDOW_ZERO = '0;
   localparam logic [sdc_pkg::CFG_WIDTH-1:0] WINDOW_PAIR = sdc_pkg::CFG_WIDTH'(2);

   typedef enum {
      VALS_WALK,
      VALS_FULL,
      VALS_POOL
   } value_mode_type;

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   logic [sdc_pkg::VALUE_WIDTH-1:0] req_value;
   logic                            req_restart;
   logic                            rsp_valid;
   logic                            rsp_stall;
   logic [sdc_pkg::OUT_WIDTH-1:0]   rsp_distinct_count;
   logic                            csr_valid;
   logic                            csr_ready;
   logic [sdc_pkg::CFG_WIDTH-1:0]   csr_window_size;

   int                              mismatch_count;
   int                              pending_words;
   bit                              sender_no_gap;

   sliding_window_distinct_count uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_value          (req_value),
      .req_restart        (req_restart),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_distinct_count (rsp_distinct_count),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_window_size    (csr_window_size)
   );

   distinct_count_checker checker_i (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_value          (req_value),
      .req_restart        (req_restart),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_distinct_count (rsp_distinct_count),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_window_size    (csr_window_size),
      .mismatch_count     (mismatch_count),
      .pending_words      (pending_words)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Offer one element word; enter and leave at a falling edge
   task automatic send_element(input logic [sdc_pkg::VALUE_WIDTH-1:0] v, input logic r);
      int unsigned gap;
      gap = sender_no_gap ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_value   <= v;
      req_restart <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // Drain the block, then write a new window size
   task automatic write_window(input logic [sdc_pkg::CFG_WIDTH-1:0] ws);
      req_valid <= 1'b0;
      while (pending_words != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      while (req_stall) @(negedge clock);
      csr_valid       <= 1'b1;
      csr_window_size <= ws;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Stimulus and verdict
   initial begin : stimulus
      int unsigned    sent;
      int unsigned    phase;
      int unsigned    kind;
      int unsigned    span;
      int unsigned    ws;
      int unsigned    base;
      int unsigned    step;
      int unsigned    pool;
      int unsigned    restart_pct;
      value_mode_type mode;
      logic [sdc_pkg::VALUE_WIDTH-1:0] v;
      logic           r;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_value       = '0;
      req_restart     = 1'b0;
      csr_valid       = 1'b0;
      csr_window_size = '0;
      sender_no_gap   = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // default window of four: extremes, repeats, a value leaving as it arrives
      send_element(10'd0, 1'b0);
      send_element(10'd1023, 1'b0);
      send_element(10'd0, 1'b0);
      send_element(10'd512, 1'b0);
      send_element(10'd0, 1'b0);
      send_element(10'd1023, 1'b0);
      send_element(10'd1, 1'b0);
      // restart mid-stream, then a window of one value only
      send_element(10'd5, 1'b1);
      send_element(10'd5, 1'b0);
      send_element(10'd5, 1'b0);
      send_element(10'd5, 1'b0);
      send_element(10'd6, 1'b0);
      // zero window acts as one
      write_window(WINDOW_ZERO);
      send_element(10'd1023, 1'b0);
      send_element(10'd1023, 1'b0);
      send_element(10'd0, 1'b1);
      write_window(WINDOW_PAIR);
      send_element(10'd3, 1'b0);
      send_element(10'd3, 1'b0);
      send_element(10'd4, 1'b0);
      send_element(10'd3, 1'b1);

      // random phases, each with its own window and value mix
      sent  = 0;
      phase = 0;
      while (sent < STIMULUS_ITEMS) begin
         kind          = (phase < 2) ? phase : $urandom_range(0, 9);
         sender_no_gap = ($urandom_range(0, 3) == 0);
         base          = $urandom_range(0, 1023);
         step          = 2 * $urandom_range(0, 511) + 1;
         pool          = 8;
         case (kind)
            0: begin
               // largest window, written as exactly max, all ones or oversize
               case ($urandom_range(0, 2))
                  0:       ws = sdc_pkg::WINDOW_MAX;
                  1:       ws = (1 << sdc_pkg::CFG_WIDTH) - 1;
                  default: ws = $urandom_range(sdc_pkg::WINDOW_MAX + 1,
                                               (1 << sdc_pkg::CFG_WIDTH) - 1);
               endcase
               span        = $urandom_range(300, 400);
               mode        = (phase == 0 || $urandom_range(0, 1) == 0) ? VALS_WALK : VALS_FULL;
               restart_pct = 0;
            end
            1: begin
               // short sequences broken by frequent restarts
               ws          = $urandom_range(1, 3);
               span        = 400;
               mode        = VALS_POOL;
               restart_pct = 65;
            end
            2: begin
               ws          = $urandom_range(0, 1);
               span        = 60;
               mode        = VALS_FULL;
               restart_pct = 6;
            end
            default: begin
               ws          = $urandom_range(2, 24);
               span        = $urandom_range(80, 160);
               mode        = ($urandom_range(0, 1) == 0) ? VALS_POOL : VALS_FULL;
               pool        = $urandom_range(1, 2 * ws + 1);
               restart_pct = 3;
            end
         endcase
         write_window(sdc_pkg::CFG_WIDTH'(ws));
         for (int k = 0; k < span; k++) begin
            case (mode)
               VALS_WALK: v = sdc_pkg::VALUE_WIDTH'(base + k * step);
               VALS_FULL: v = sdc_pkg::VALUE_WIDTH'($urandom_range(0, 1023));
               default:   v = sdc_pkg::VALUE_WIDTH'(base + $urandom_range(0, pool - 1));
            endcase
            r = ($urandom_range(0, 99) < restart_pct);
            send_element(v, r);
         end
         sent += span;
         phase++;
      end

      // wait out every pending word, then a little longer for strays
      req_valid <= 1'b0;
      while (pending_words != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("sliding_window_distinct_count verification clean");
      end else begin
         $display("sliding_window_distinct_count verification failed");
      end
      $finish;
   end

   // Result receiver: random stalls, one long hold-off to back up the block
   initial begin : result_sink
      int unsigned taken;
      int unsigned hold;
      bit          no_stall;
      taken     = 0;
      no_stall  = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (taken == HOLD_AT_RESULT) begin
            hold = LONG_HOLD_CYCLES;
         end else begin
            hold = no_stall ? 0 : $urandom_range(0, MAX_GAP);
         end
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
            rsp_stall <= 1'b0;
         end
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         taken++;
         if (taken % 64 == 0) begin
            no_stall = ($urandom_range(0, 3) == 0);
         end
      end
   end

   // Cycle limit
   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("sliding_window_distinct_count verification failed");
      $finish;
   end

endmodule

@@ sim.f @@
hdl/sdc_pkg.sv
hdl/sdc_ram.sv
hdl/sdc_count_store.sv
hdl/sdc_rsp_queue.sv
hdl/sliding_window_distinct_count.sv
tb/sv/distinct_count_checker.sv
tb/sv/tb_top.sv
